// ----- sv/sobel_pkg.sv -----
// ----------------------------------------------------------------------------
// Sobel package
// Widths and shared constants for the Sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;
  localparam int unsigned CfgWidth = 12;
  localparam int unsigned RowBits  = 12;
  localparam int unsigned GradBits = 11;
  localparam int unsigned MagBits  = 11;
  localparam int unsigned SqBits   = 22;
  localparam logic [11:0] HeightLimit = 12'd4095;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;
endpackage

// ----- sv/sobel_ram.sv -----
// ----------------------------------------------------------------------------
// Sobel RAM
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module sobel_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

// ----- sv/sobel_edge_magnitude.sv -----
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Pixel in, 3x3 Sobel gradients and their floor square-root magnitude out.
// ----------------------------------------------------------------------------
// A pixel is taken while both line stores are read, then passes a write-back
// state that also computes the gradients; a border pixel ends there. An
// interior pixel adds a squaring state and square-root steps of one result
// bit each, and the next pixel is taken only once its result is registered;
// a full output register holds the root unit and stalls the input.
// Line stores have no reset; window, position and control state clear on reset.
module sobel_edge_magnitude
  import sobel_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CfgWidth-1:0]   cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [PIXEL_BITS-1:0] pixel_value_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [MagBits-1:0]    magnitude_o,
  output logic signed [GradBits-1:0] grad_rows_o,
  output logic signed [GradBits-1:0] grad_cols_o,
  output logic [RowBits-1:0]    out_row_o,
  output logic [10:0]           out_col_o,
  output logic                  frame_last_o
);
  localparam int unsigned AddrBits = $clog2(MAX_WIDTH);
  localparam int unsigned ColBits  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned GB       = PIXEL_BITS + 4;
  localparam int unsigned SB       = 2 * GB;
  localparam int unsigned RootBits = GB;
  localparam int unsigned Steps    = (SB + 1) / 2;
  localparam int unsigned StepBits = $clog2(Steps + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCalc = 2'd2;
  localparam logic [1:0] StRoot = 2'd3;

  logic [CfgWidth-1:0] width_cfg_q, height_cfg_q;
  logic [1:0]          state_q, state_d;
  logic [PIXEL_BITS-1:0] pix_q;
  logic [ColBits-1:0]  col_q, col_d, c_q;
  logic [RowBits-1:0]  row_q, row_d, r_q;
  logic [PIXEL_BITS-1:0] win_q [9];
  logic [PIXEL_BITS-1:0] up_rd, mid_rd;
  logic                last_q;

  logic [ColBits-1:0] eff_w;
  logic [RowBits-1:0] eff_h;
  always_comb begin
    if (width_cfg_q < CfgWidth'(3)) eff_w = ColBits'(3);
    else if (32'(width_cfg_q) > 32'(MAX_WIDTH)) eff_w = ColBits'(MAX_WIDTH);
    else eff_w = ColBits'(width_cfg_q);
    if (height_cfg_q < 12'd3) eff_h = 12'd3;
    else if (height_cfg_q > HeightLimit) eff_h = HeightLimit;
    else eff_h = height_cfg_q;
  end

  // Position of the accepted pixel after frame start and wrap handling.
  logic [ColBits-1:0] c_now;
  logic [RowBits-1:0] r_now;
  always_comb begin
    c_now = frame_start_i ? '0 : col_q;
    r_now = frame_start_i ? '0 : row_q;
    if (c_now >= eff_w) begin
      c_now = '0;
      r_now = r_now + 1'b1;
    end
    if (r_now >= eff_h) r_now = '0;
  end

  logic accept;
  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;

  logic [AddrBits-1:0] addr;
  assign addr = accept ? c_now[AddrBits-1:0] : c_q[AddrBits-1:0];

  logic ls_we;
  assign ls_we = (state_q == StRead);

  sobel_ram #(.Width(PIXEL_BITS), .Depth(MAX_WIDTH)) u_upper (
    .clk_i, .we_i(ls_we), .waddr_i(addr), .wdata_i(mid_rd),
    .re_i(accept), .raddr_i(addr), .rdata_o(up_rd)
  );
  sobel_ram #(.Width(PIXEL_BITS), .Depth(MAX_WIDTH)) u_middle (
    .clk_i, .we_i(ls_we), .waddr_i(addr), .wdata_i(pix_q),
    .re_i(accept), .raddr_i(addr), .rdata_o(mid_rd)
  );

  // Gradients from the shifted window.
  logic signed [GB-1:0] gr_d, gc_d, gr_q, gc_q;
  logic [PIXEL_BITS-1:0] w [9];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      w[k*3]   = win_q[k*3+1];
      w[k*3+1] = win_q[k*3+2];
    end
    w[2] = up_rd;
    w[5] = mid_rd;
    w[8] = pix_q;
    gr_d = (GB'(w[6]) + (GB'(w[7]) << 1) + GB'(w[8]))
         - (GB'(w[0]) + (GB'(w[1]) << 1) + GB'(w[2]));
    gc_d = (GB'(w[2]) + (GB'(w[5]) << 1) + GB'(w[8]))
         - (GB'(w[0]) + (GB'(w[3]) << 1) + GB'(w[6]));
  end

  // Square root: the sum of squares is formed in the calc cycle from
  // registered gradients, then resolved two bits per cycle, one root bit for each pair.
  logic [SB-1:0]       rem_q, rem_d;
  logic [RootBits-1:0] root_q, root_d;
  logic [StepBits-1:0] step_q;
  logic signed [SB-1:0] gr_sq, gc_sq;
  logic [SB-1:0]       sq_in;
  logic [SB+1:0]       trial;
  logic [RootBits+1:0] trial_root;
  logic [SB+1:0]       rem_sh;
  logic [SB-1:0]       sq_q;
  logic                interior_q;

  always_comb begin
    gr_sq = gr_q * gr_q;
    gc_sq = gc_q * gc_q;
    sq_in = $unsigned(gr_sq) + $unsigned(gc_sq);
    rem_sh = {rem_q, sq_q[SB-1 -: 2]};
    trial_root = {root_q, 2'b01};
    trial = rem_sh - (SB+2)'(trial_root);
    if (!trial[SB+1]) begin
      rem_d  = trial[SB-1:0];
      root_d = {root_q[RootBits-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh[SB-1:0];
      root_d = {root_q[RootBits-2:0], 1'b0};
    end
  end

  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    col_d = col_q;
    row_d = row_q;
    case (state_q)
      StIdle: if (accept) begin
        state_d = StRead;
        col_d = c_now + 1'b1;
        row_d = r_now;
        if (c_now + 1'b1 >= eff_w) begin
          col_d = '0;
          row_d = (r_now + 1'b1 >= eff_h) ? '0 : r_now + 1'b1;
        end
      end
      StRead: state_d = (r_q >= 2 && c_q >= 2) ? StCalc : StIdle;
      StCalc: state_d = StRoot;
      StRoot: if (step_q == StepBits'(Steps) && out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_cfg_q  <= 12'd640;
      height_cfg_q <= 12'd480;
      state_q <= StIdle;
      col_q <= '0;
      row_q <= '0;
      out_valid_o <= 1'b0;
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_IMAGE_WIDTH) width_cfg_q <= cfg_data_i;
        else height_cfg_q <= cfg_data_i;
      end
      state_q <= state_d;
      col_q <= col_d;
      row_q <= row_d;
      if (state_q == StRead) begin
        for (int k = 0; k < 9; k++) win_q[k] <= w[k];
      end
      if (state_q == StRoot && step_q == StepBits'(Steps) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_q <= pixel_value_i;
      c_q <= c_now;
      r_q <= r_now;
      last_q <= (r_now == eff_h - 1'b1) && (c_now == eff_w - 1'b1);
    end
    if (state_q == StRead) begin
      gr_q <= gr_d;
      gc_q <= gc_d;
      interior_q <= 1'b1;
    end
    if (state_q == StCalc) begin
      sq_q <= sq_in;
      rem_q <= '0;
      root_q <= '0;
      step_q <= '0;
    end
    if (state_q == StRoot && step_q != StepBits'(Steps)) begin
      sq_q <= sq_q << 2;
      rem_q <= rem_d;
      root_q <= root_d;
      step_q <= step_q + 1'b1;
    end
    if (state_q == StRoot && step_q == StepBits'(Steps) && out_free) begin
      magnitude_o  <= MagBits'(root_q);
      grad_rows_o  <= GradBits'(gr_q);
      grad_cols_o  <= GradBits'(gc_q);
      out_row_o    <= RowBits'(r_q - 1'b1);
      out_col_o    <= 11'(c_q - 1'b1);
      frame_last_o <= last_q && interior_q;
    end
  end
endmodule

// ----- sv/sobel_checker.sv -----
// ----------------------------------------------------------------------------
// Sobel checker
// Port-level checks on the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
module sobel_checker
  import sobel_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [MagBits-1:0] magnitude_o,
  input logic [10:0] out_col_o,
  input logic [RowBits-1:0] out_row_o
);
  // A transfer in is followed by a busy cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("ready after transfer");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(magnitude_o))
    else $error("result dropped");
  a_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_col_o != 11'd0 && out_row_o != '0)
    else $error("border result");
  a_mag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> magnitude_o <= 11'd1443) else $error("magnitude range");
endmodule

bind sobel_edge_magnitude sobel_checker u_sobel_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .magnitude_o, .out_col_o, .out_row_o
);
